// File: rtl/mpam_pkg.sv
// Shared types, constants and helper functions for the max-pool argmax block.
// Used by every module under rtl/; depends on nothing else.
package mpam_pkg;

  // Plane and window limits
  localparam int MAX_WINDOW = 8;
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_SLOTS  = 256;

  // Field widths
  localparam int PIX_W   = 16;
  localparam int POS_W   = 8;
  localparam int OFF_W   = 3;
  localparam int WS_W    = 4;
  localparam int DIM_W   = 9;
  localparam int SLOT_W  = 8;
  localparam int RECIP_W = 17;
  localparam int PROD_W  = POS_W + RECIP_W;

  // Configuration port
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [WS_W-1:0]  WS_RESET  = 4'd2;
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // Result queue
  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PW    = 2;

  // Effective (clamped) configuration
  typedef struct packed {
    logic [WS_W-1:0]  ws;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } cfg_t;

  // One window-column entry of the state memory
  typedef struct packed {
    logic [PIX_W-1:0] max;
    logic [OFF_W-1:0] row;
    logic [OFF_W-1:0] col;
  } win_entry_t;

  // Item travelling from the position stage to the update stage
  typedef struct packed {
    logic [PIX_W-1:0]  value;
    logic [SLOT_W-1:0] slot;
    logic [POS_W-1:0]  wrow;
    logic [OFF_W-1:0]  rib;
    logic [OFF_W-1:0]  ciw;
    logic              first;
    logic              emit;
    logic              last;
  } pix_t;

  // One result item
  typedef struct packed {
    logic [POS_W-1:0] wrow;
    logic [POS_W-1:0] wcol;
    logic [OFF_W-1:0] orow;
    logic [OFF_W-1:0] ocol;
    logic             pdone;
  } res_t;

  // Rounded-up reciprocal 2^16/ws; exact quotient for 8-bit dividends
  function automatic logic [RECIP_W-1:0] ws_recip(input logic [WS_W-1:0] ws);
    logic [RECIP_W-1:0] r;
    unique case (ws)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  // Divide a position by the window size through reciprocal multiply
  function automatic logic [POS_W-1:0] div_ws(input logic [POS_W-1:0] x,
                                              input logic [WS_W-1:0] ws);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(x) * PROD_W'(ws_recip(ws));
    return prod[POS_W+15:16];
  endfunction

endpackage

// File: rtl/mpam_cfg_regs.sv
// APB-style register bank: window size, image width and image height.
// Depends on mpam_pkg; hands clamped values to the datapath.
module mpam_cfg_regs import mpam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  logic [WS_W-1:0]  ws_q;
  logic [DIM_W-1:0] w_q;
  logic [DIM_W-1:0] h_q;
  logic [IDX_W-1:0] reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[IDX_W+1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Capture register writes on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ws_q <= WS_RESET;
      w_q  <= DIM_RESET;
      h_q  <= DIM_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WINDOW_SIZE:  ws_q <= pwdata[WS_W-1:0];
        REG_IMAGE_WIDTH:  w_q  <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: h_q  <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the raw register contents
  always_comb begin
    unique case (reg_idx)
      REG_WINDOW_SIZE:  prdata = APB_DW'(ws_q);
      REG_IMAGE_WIDTH:  prdata = APB_DW'(w_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(h_q);
      default:          prdata = '0;
    endcase
  end

  // Clamp zero to one and large values to the limits
  always_comb begin
    if (ws_q == '0)                       cfg_o.ws = WS_W'(1);
    else if (ws_q > WS_W'(MAX_WINDOW))    cfg_o.ws = WS_W'(MAX_WINDOW);
    else                                  cfg_o.ws = ws_q;
    if (w_q == '0)                        cfg_o.w = DIM_W'(1);
    else if (w_q > DIM_W'(MAX_WIDTH))     cfg_o.w = DIM_W'(MAX_WIDTH);
    else                                  cfg_o.w = w_q;
    if (h_q == '0)                        cfg_o.h = DIM_W'(1);
    else if (h_q > DIM_W'(MAX_HEIGHT))    cfg_o.h = DIM_W'(MAX_HEIGHT);
    else                                  cfg_o.h = h_q;
  end

endmodule

// File: rtl/mpam_pos_ctrl.sv
// Raster position counters and window addressing for each accepted item.
// Depends on mpam_pkg; issues the state memory read and feeds the update stage.
module mpam_pos_ctrl import mpam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              accept_i,
  input  logic [PIX_W-1:0]  pixel_value_i,
  output logic [SLOT_W-1:0] rd_addr_o,
  output logic              b_valid_o,
  output pix_t              pix_o
);

  logic [POS_W-1:0] pixel_row_q, pixel_row_d;
  logic [POS_W-1:0] pixel_col_q, pixel_col_d;
  logic [OFF_W-1:0] rib_q, rib_d;
  logic [OFF_W-1:0] ciw_q, ciw_d;
  logic             b_valid_q;
  pix_t             pix_q;

  logic [DIM_W-1:0] col_next;
  logic [DIM_W-1:0] row_next;
  logic [WS_W-1:0]  rib_next;
  logic [WS_W-1:0]  ciw_next;
  logic             row_end;
  logic             plane_end;
  logic             band_end;
  logic             win_col_end;
  logic [SLOT_W-1:0] slot;
  logic [POS_W-1:0]  wrow;

  // Work out where this item sits in the plane
  always_comb begin
    col_next    = DIM_W'(pixel_col_q) + DIM_W'(1);
    row_next    = DIM_W'(pixel_row_q) + DIM_W'(1);
    rib_next    = WS_W'(rib_q) + WS_W'(1);
    ciw_next    = WS_W'(ciw_q) + WS_W'(1);
    row_end     = col_next >= cfg_i.w;
    plane_end   = row_next >= cfg_i.h;
    band_end    = (rib_next >= cfg_i.ws) || plane_end;
    win_col_end = (ciw_next >= cfg_i.ws) || row_end;
    slot        = div_ws(pixel_col_q, cfg_i.ws);
    wrow        = div_ws(pixel_row_q, cfg_i.ws);
  end

  assign rd_addr_o = slot;

  // Advance the counters, wrapping at row, window and plane ends
  always_comb begin
    pixel_row_d = pixel_row_q;
    pixel_col_d = pixel_col_q;
    rib_d       = rib_q;
    ciw_d       = ciw_q;
    if (row_end) begin
      pixel_col_d = '0;
      ciw_d       = '0;
      if (plane_end) begin
        pixel_row_d = '0;
        rib_d       = '0;
      end else begin
        pixel_row_d = row_next[POS_W-1:0];
        rib_d       = (rib_next >= cfg_i.ws) ? '0 : rib_next[OFF_W-1:0];
      end
    end else begin
      pixel_col_d = col_next[POS_W-1:0];
      ciw_d       = (ciw_next >= cfg_i.ws) ? '0 : ciw_next[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_row_q <= '0;
      pixel_col_q <= '0;
      rib_q       <= '0;
      ciw_q       <= '0;
      b_valid_q   <= 1'b0;
    end else begin
      b_valid_q <= accept_i;
      if (accept_i) begin
        pixel_row_q <= pixel_row_d;
        pixel_col_q <= pixel_col_d;
        rib_q       <= rib_d;
        ciw_q       <= ciw_d;
      end
    end
  end

  // Hand the item to the update stage
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      pix_q.value <= pixel_value_i;
      pix_q.slot  <= slot;
      pix_q.wrow  <= wrow;
      pix_q.rib   <= rib_q;
      pix_q.ciw   <= ciw_q;
      pix_q.first <= (rib_q == '0) && (ciw_q == '0);
      pix_q.emit  <= band_end && win_col_end;
      pix_q.last  <= row_end && plane_end;
    end
  end

  assign b_valid_o = b_valid_q;
  assign pix_o     = pix_q;

endmodule

// File: rtl/mpam_win_ram.sv
// Per-window-column state memory with read-modify-write update and forwarding.
// Depends on mpam_pkg; produces a result item when a window completes.
module mpam_win_ram import mpam_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  input  logic              b_valid_i,
  input  pix_t              pix_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  win_entry_t        mem [COL_SLOTS];
  win_entry_t        rd_q;
  logic              fwd_valid_q;
  logic [SLOT_W-1:0] fwd_addr_q;
  win_entry_t        fwd_data_q;
  win_entry_t        cur;
  win_entry_t        upd;

  // Read the entry for the item being accepted
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // Take the previous write when it hit the same entry at the read edge
  always_comb begin
    cur = rd_q;
    if (fwd_valid_q && (fwd_addr_q == pix_i.slot)) begin
      cur = fwd_data_q;
    end
  end

  // Start a window, or replace the maximum only on a strictly greater value
  always_comb begin
    upd = cur;
    if (pix_i.first) begin
      upd.max = pix_i.value;
      upd.row = '0;
      upd.col = '0;
    end else if ($signed(pix_i.value) > $signed(cur.max)) begin
      upd.max = pix_i.value;
      upd.row = pix_i.rib;
      upd.col = pix_i.ciw;
    end
  end

  // Write back the updated entry
  always_ff @(posedge clk_i) begin
    if (b_valid_i) begin
      mem[pix_i.slot] <= upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= b_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= pix_i.slot;
    fwd_data_q <= upd;
  end

  assign res_valid_o = b_valid_i && pix_i.emit;
  assign res_o.wrow  = pix_i.wrow;
  assign res_o.wcol  = pix_i.slot;
  assign res_o.orow  = upd.row;
  assign res_o.ocol  = upd.col;
  assign res_o.pdone = pix_i.last;

endmodule

// File: rtl/mpam_out_fifo.sv
// Three-entry result queue that decouples the update stage from the consumer.
// Depends on mpam_pkg for the result item type.
module mpam_out_fifo import mpam_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  res_t               push_data_i,
  input  logic               pop_ready_i,
  output logic               pop_valid_o,
  output res_t               pop_data_o,
  output logic [FIFO_PW-1:0] count_o
);

  res_t               fifo_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q;
  logic [FIFO_PW-1:0] rd_ptr_q;
  logic [FIFO_PW-1:0] cnt_q;
  logic               pop;

  assign pop_valid_o = cnt_q != '0;
  assign pop         = pop_valid_o && pop_ready_i;
  assign pop_data_o  = fifo_q[rd_ptr_q];
  assign count_o     = cnt_q;

  function automatic logic [FIFO_PW-1:0] ptr_inc(input logic [FIFO_PW-1:0] p);
    return (p == FIFO_PW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PW'(1);
  endfunction

  // Store pushed items
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      fifo_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop)    rd_ptr_q <= ptr_inc(rd_ptr_q);
      cnt_q <= cnt_q + FIFO_PW'(push_i) - FIFO_PW'(pop);
    end
  end

endmodule

// File: rtl/max_pool_argmax_mask_core.sv
// Max-pool argmax over a raster pixel stream, one item per cycle unless stalled.
// A window's last item passes the position stage and the update stage, which pushes
// its result item into the result queue; it waits there until it is taken.
// Throughput: one item, state memory read and write-back per cycle while not stalled.
// Reset clears counters, result queue and registers (size 2, 256 x 256);
// the window memory is not cleared; a window's first item ignores the stored entry.
module max_pool_argmax_mask_core import mpam_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [PIX_W-1:0]  pixel_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [POS_W-1:0]         window_row_o,
  output logic [POS_W-1:0]         window_col_o,
  output logic [OFF_W-1:0]         offset_row_o,
  output logic [OFF_W-1:0]         offset_col_o,
  output logic                     plane_done_o
);

  cfg_t               cfg;
  logic               accept;
  logic [SLOT_W-1:0]  rd_addr;
  logic               b_valid;
  pix_t               pix;
  logic               res_valid;
  res_t               res;
  res_t               out_res;
  logic [FIFO_PW-1:0] fifo_cnt;

  // Accept while the queue can take the result of the item in flight too
  assign in_ready_o = (3'(fifo_cnt) + 3'(b_valid)) <= 3'(FIFO_DEPTH - 1);
  assign accept     = in_valid_i && in_ready_o;

  mpam_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mpam_pos_ctrl u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .accept_i      (accept),
    .pixel_value_i (pixel_value_i),
    .rd_addr_o     (rd_addr),
    .b_valid_o     (b_valid),
    .pix_o         (pix)
  );

  mpam_win_ram u_ram (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (accept),
    .rd_addr_i   (rd_addr),
    .b_valid_i   (b_valid),
    .pix_i       (pix),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mpam_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_ready_i (out_ready_i),
    .pop_valid_o (out_valid_o),
    .pop_data_o  (out_res),
    .count_o     (fifo_cnt)
  );

  assign window_row_o = out_res.wrow;
  assign window_col_o = out_res.wcol;
  assign offset_row_o = out_res.orow;
  assign offset_col_o = out_res.ocol;
  assign plane_done_o = out_res.pdone;

endmodule

// File: rtl/mpam_checker.sv
// Port-level checks for the max-pool argmax core, attached by bind.
// Depends on mpam_pkg for widths; sees the top-level ports only.
module mpam_port_checker import mpam_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic signed [PIX_W-1:0] pixel_value_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [POS_W-1:0]        window_row_o,
  input logic [POS_W-1:0]        window_col_o,
  input logic [OFF_W-1:0]        offset_row_o,
  input logic [OFF_W-1:0]        offset_col_o,
  input logic                    plane_done_o
);

  // A stalled result item holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(window_row_o) &&
      $stable(window_col_o) && $stable(offset_row_o) && $stable(offset_col_o) &&
      $stable(plane_done_o))
    else $error("result item changed while stalled");

  // A result item only appears as the result of an accepted input item
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result item without a matching input item");

  // Back-pressure only while results are waiting
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  // A stalled input item holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> $stable(pixel_value_i))
    else $error("input item changed while stalled");

endmodule

bind max_pool_argmax_mask_core mpam_port_checker u_mpam_checker (.*);
